// ===== rtl/mwkrp_pkg.sv =====
`timescale 1ns / 1ps
package mwkrp_pkg;

  localparam int MaxLen    = 256;
  localparam int ValueBits = 20;
  localparam int IdxW      = $clog2(MaxLen);
  localparam int CntW      = IdxW + 1;
  localparam int PsW       = 28;
  localparam int CostW     = 29;
  localparam int WasteW    = 28;
  localparam int KW        = 8;
  localparam int VpW       = ValueBits + PsW;
  localparam int CostDepth = 2 * MaxLen;
  localparam int CostAddrW = IdxW + 1;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 32;

  // Register index of max_resizes.
  localparam logic RegMaxResizes = 1'b0;

endpackage

// ===== rtl/mwkrp_in_if.sv =====
`timescale 1ns / 1ps
interface mwkrp_in_if;
  logic                           valid;
  logic                           ready;
  logic [mwkrp_pkg::ValueBits-1:0] size_value;
  logic                           last_value;

  modport source (output valid, output size_value, output last_value, input ready);
  modport sink (input valid, input size_value, input last_value, output ready);
endinterface

// ===== rtl/mwkrp_out_if.sv =====
`timescale 1ns / 1ps
interface mwkrp_out_if;
  logic                         valid;
  logic                         ready;
  logic [mwkrp_pkg::WasteW-1:0] total_waste;
  logic                         overflow;

  modport source (output valid, output total_waste, output overflow, input ready);
  modport sink (input valid, input total_waste, input overflow, output ready);
endinterface

// ===== rtl/min_waste_k_resize_partition.sv =====
`timescale 1ns / 1ps
// Minimum-waste partition of a size sequence into at most max_resizes+1 segments.
// Sizes arrive on in_i, one item per cycle while the block is loading; the item
// with last_value set closes the sequence. Items beyond the store depth are
// dropped and flagged in the overflow field of the result.
// On the closing item in_i.ready falls and the block runs the segment DP out of
// its memories, working through the candidate split points one after another;
// the sweep covers max_resizes rows. The rate is set by the single read port of
// the value/prefix memory and of the cost memory.
// A short sequence, or one with at least length-1 resizes, skips the DP and
// answers with zero waste from the finishing state.
// The result item is held in an output register until out_o.ready; while the
// receiver stalls, no new size is taken. After it is taken, loading restarts.
// max_resizes is to be written over the APB port only while no sequence is open;
// the block does not enforce this. Reset clears the counters and the sequencer;
// the memories need no clearing: only entries written in this sequence are read.
module min_waste_k_resize_partition (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mwkrp_in_if.sink                      in_i,
  mwkrp_out_if.source                   out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwkrp_pkg::CfgAddrW-1:0] paddr,
  input  logic [mwkrp_pkg::CfgDataW-1:0] pwdata,
  output logic [mwkrp_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  typedef enum logic [3:0] {
    StLoad, StFin, StInit, StCand, StDrain, StRd, StRdWait, StOut
  } state_e;

  state_e state_q;

  logic [mwkrp_pkg::KW-1:0]        k_q;
  logic [mwkrp_pkg::CntW-1:0]      cnt_q;
  logic                            drop_q;
  logic [mwkrp_pkg::PsW-1:0]       ps_q;
  logic [mwkrp_pkg::ValueBits-1:0] lmax_q;
  logic [mwkrp_pkg::CntW-1:0]      s_q;
  logic [mwkrp_pkg::IdxW-1:0]      i_q;
  logic [mwkrp_pkg::IdxW-1:0]      x_q;
  logic                            par_q;
  logic                            out_v_q;
  logic [mwkrp_pkg::WasteW-1:0]    out_w_q;
  logic                            out_ovf_q;

  // Delayed write of the one-segment cost row while loading.
  logic                            r0_v_q;
  logic [mwkrp_pkg::IdxW-1:0]      r0_idx_q;
  logic [mwkrp_pkg::ValueBits-1:0] r0_max_q;
  logic [mwkrp_pkg::PsW-1:0]       r0_ps_q;

  // Candidate pipeline.
  logic                            p1_v_q, p1_init_q;
  logic [mwkrp_pkg::IdxW-1:0]      p1_x_q;
  logic                            p2_v_q;
  logic [mwkrp_pkg::ValueBits-1:0] p2_mx_q;
  logic [mwkrp_pkg::CntW-1:0]      p2_len_q;
  logic [mwkrp_pkg::PsW-1:0]       p2_sum_q;
  logic [mwkrp_pkg::CostW-1:0]     p2_cp_q;
  logic                            p3_v_q;
  logic [mwkrp_pkg::CostW-1:0]     p3_prod_q;
  logic [mwkrp_pkg::PsW-1:0]       p3_sum_q;
  logic [mwkrp_pkg::CostW-1:0]     p3_cp_q;
  logic [mwkrp_pkg::ValueBits-1:0] rmax_q;
  logic [mwkrp_pkg::PsW-1:0]       psi_q;
  logic [mwkrp_pkg::CostW-1:0]     best_q;

  // Memory ports.
  logic                            vp_we;
  logic [mwkrp_pkg::IdxW-1:0]      vp_waddr, vp_raddr;
  logic [mwkrp_pkg::VpW-1:0]       vp_wdata, vp_rdata;
  logic                            c_we;
  logic [mwkrp_pkg::CostAddrW-1:0] c_waddr, c_raddr;
  logic [mwkrp_pkg::CostW-1:0]     c_wdata, c_rdata;

  logic                            in_acc, out_acc, cfg_we;
  logic [mwkrp_pkg::ValueBits-1:0] in_val, new_lmax;
  logic [mwkrp_pkg::PsW-1:0]       new_ps;
  logic [mwkrp_pkg::CntW-1:0]      segs;
  logic [mwkrp_pkg::IdxW-1:0]      last_idx;
  logic                            pipe_busy;
  logic [mwkrp_pkg::ValueBits-1:0] rd_val, c1_max;
  logic [mwkrp_pkg::PsW-1:0]       rd_ps;
  logic [mwkrp_pkg::CostW-1:0]     r0_cost;
  logic [mwkrp_pkg::CostW:0]       cand;
  logic [mwkrp_pkg::PsW-1:0]       seg_w;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_v_q && out_o.ready;
  assign cfg_we  = psel && penable && pwrite && pready
                   && (paddr[2] == mwkrp_pkg::RegMaxResizes);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mwkrp_pkg::RegMaxResizes)
                  ? {{(mwkrp_pkg::CfgDataW - mwkrp_pkg::KW){1'b0}}, k_q}
                  : '0;

  assign in_i.ready        = (state_q == StLoad);
  assign out_o.valid       = out_v_q;
  assign out_o.total_waste = out_w_q;
  assign out_o.overflow    = out_ovf_q;

  assign in_val   = in_i.size_value;
  assign new_lmax = (in_val > lmax_q) ? in_val : lmax_q;
  assign new_ps   = ps_q + mwkrp_pkg::PsW'(in_val);
  assign segs     = mwkrp_pkg::CntW'(k_q) + mwkrp_pkg::CntW'(1);
  assign last_idx = mwkrp_pkg::IdxW'(cnt_q - mwkrp_pkg::CntW'(1));
  assign pipe_busy = p1_v_q || p2_v_q || p3_v_q;

  assign rd_val = vp_rdata[mwkrp_pkg::VpW-1 -: mwkrp_pkg::ValueBits];
  assign rd_ps  = vp_rdata[mwkrp_pkg::PsW-1:0];
  assign c1_max = (rd_val > rmax_q) ? rd_val : rmax_q;

  assign r0_cost = mwkrp_pkg::CostW'(r0_max_q * (mwkrp_pkg::CntW'(r0_idx_q)
                   + mwkrp_pkg::CntW'(1))) - mwkrp_pkg::CostW'(r0_ps_q);

  assign seg_w = mwkrp_pkg::PsW'(p3_prod_q) - p3_sum_q;
  assign cand  = (mwkrp_pkg::CostW+1)'(p3_cp_q) + (mwkrp_pkg::CostW+1)'(seg_w);

  // Each value is stored with the prefix sum of the values before it.
  assign vp_we    = in_acc && (cnt_q < mwkrp_pkg::CntW'(mwkrp_pkg::MaxLen));
  assign vp_waddr = cnt_q[mwkrp_pkg::IdxW-1:0];
  assign vp_wdata = {in_val, ps_q};
  assign vp_raddr = (state_q == StInit) ? i_q : x_q;

  always_comb begin
    c_we    = 1'b0;
    c_waddr = {1'b0, r0_idx_q};
    c_wdata = r0_cost;
    if (r0_v_q) begin
      c_we = 1'b1;
    end else if (state_q == StDrain && !pipe_busy) begin
      c_we    = 1'b1;
      c_waddr = {~par_q, i_q};
      c_wdata = best_q;
    end
  end

  always_comb begin
    case (state_q)
      StInit:  c_raddr = {par_q, i_q};
      StCand:  c_raddr = {par_q, x_q - mwkrp_pkg::IdxW'(1)};
      default: c_raddr = {par_q, last_idx};
    endcase
  end

  mwkrp_ram #(.Width(mwkrp_pkg::VpW), .Depth(mwkrp_pkg::MaxLen)) u_vp_ram (
    .clk_i   (clk_i),
    .we_i    (vp_we),
    .waddr_i (vp_waddr),
    .wdata_i (vp_wdata),
    .raddr_i (vp_raddr),
    .rdata_o (vp_rdata)
  );

  mwkrp_ram #(.Width(mwkrp_pkg::CostW), .Depth(mwkrp_pkg::CostDepth)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cfg_we) begin
      k_q <= pwdata[mwkrp_pkg::KW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StLoad;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      ps_q      <= '0;
      lmax_q    <= '0;
      s_q       <= '0;
      i_q       <= '0;
      x_q       <= '0;
      par_q     <= 1'b0;
      out_v_q   <= 1'b0;
      out_w_q   <= '0;
      out_ovf_q <= 1'b0;
      r0_v_q    <= 1'b0;
      r0_idx_q  <= '0;
      r0_max_q  <= '0;
      r0_ps_q   <= '0;
    end else begin
      r0_v_q <= vp_we;
      case (state_q)
        StLoad: begin
          if (in_acc) begin
            if (vp_we) begin
              ps_q     <= new_ps;
              lmax_q   <= new_lmax;
              cnt_q    <= cnt_q + mwkrp_pkg::CntW'(1);
              r0_idx_q <= cnt_q[mwkrp_pkg::IdxW-1:0];
              r0_max_q <= new_lmax;
              r0_ps_q  <= new_ps;
            end else begin
              drop_q <= 1'b1;
            end
            if (in_i.last_value) begin
              state_q <= StFin;
            end
          end
        end
        StFin: begin
          par_q <= 1'b0;
          if (cnt_q <= mwkrp_pkg::CntW'(1) || segs >= cnt_q) begin
            out_v_q   <= 1'b1;
            out_w_q   <= '0;
            out_ovf_q <= drop_q;
            state_q   <= StOut;
          end else if (segs == mwkrp_pkg::CntW'(1)) begin
            state_q <= StRd;
          end else begin
            s_q     <= mwkrp_pkg::CntW'(2);
            i_q     <= '0;
            state_q <= StInit;
          end
        end
        StInit: begin
          x_q     <= i_q;
          state_q <= (i_q == '0) ? StDrain : StCand;
        end
        StCand: begin
          if (x_q == mwkrp_pkg::IdxW'(1)) begin
            state_q <= StDrain;
          end else begin
            x_q <= x_q - mwkrp_pkg::IdxW'(1);
          end
        end
        StDrain: begin
          if (!pipe_busy) begin
            if (i_q == last_idx) begin
              par_q <= ~par_q;
              i_q   <= '0;
              if (s_q == segs) begin
                state_q <= StRd;
              end else begin
                s_q     <= s_q + mwkrp_pkg::CntW'(1);
                state_q <= StInit;
              end
            end else begin
              i_q     <= i_q + mwkrp_pkg::IdxW'(1);
              state_q <= StInit;
            end
          end
        end
        StRd: begin
          state_q <= StRdWait;
        end
        StRdWait: begin
          out_v_q   <= 1'b1;
          out_w_q   <= c_rdata[mwkrp_pkg::WasteW-1:0];
          out_ovf_q <= drop_q;
          state_q   <= StOut;
        end
        StOut: begin
          if (out_acc) begin
            out_v_q <= 1'b0;
            cnt_q   <= '0;
            drop_q  <= 1'b0;
            ps_q    <= '0;
            lmax_q  <= '0;
            state_q <= StLoad;
          end
        end
        default: begin
          state_q <= StLoad;
        end
      endcase
    end
  end

  // Stage 1 sees the read data, stage 2 multiplies, stage 3 adds and compares.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q    <= 1'b0;
      p1_init_q <= 1'b0;
      p2_v_q    <= 1'b0;
      p3_v_q    <= 1'b0;
    end else begin
      p1_v_q    <= (state_q == StInit) || (state_q == StCand);
      p1_init_q <= (state_q == StInit);
      p2_v_q    <= p1_v_q && !p1_init_q;
      p3_v_q    <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_x_q <= x_q;
    if (p1_v_q) begin
      if (p1_init_q) begin
        // The first read for each entry i gives the prefix sum through element i.
        psi_q  <= rd_ps + mwkrp_pkg::PsW'(rd_val);
        best_q <= c_rdata;
        rmax_q <= '0;
      end else begin
        rmax_q   <= c1_max;
        p2_mx_q  <= c1_max;
        p2_len_q <= mwkrp_pkg::CntW'(i_q) + mwkrp_pkg::CntW'(1) - mwkrp_pkg::CntW'(p1_x_q);
        p2_sum_q <= psi_q - rd_ps;
        p2_cp_q  <= c_rdata;
      end
    end
    p3_prod_q <= mwkrp_pkg::CostW'(p2_mx_q * p2_len_q);
    p3_sum_q  <= p2_sum_q;
    p3_cp_q   <= p2_cp_q;
    if (p3_v_q && cand < (mwkrp_pkg::CostW+1)'(best_q)) begin
      best_q <= mwkrp_pkg::CostW'(cand);
    end
  end

  a_no_load_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !in_i.ready)
    else $error("input taken while a result waits");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mwkrp_pkg::CntW'(mwkrp_pkg::MaxLen))
    else $error("item count beyond store depth");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_v_q |-> $past(p2_v_q))
    else $error("pipeline stage skipped");

  a_row_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain && !pipe_busy) |-> !r0_v_q)
    else $error("cost write collision");

endmodule

// ===== rtl/mwkrp_ram.sv =====
`timescale 1ns / 1ps
module mwkrp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sim/mwkrp_checker.sv =====
`timescale 1ns / 1ps
module mwkrp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mwkrp_in_if                            in_ch,
  mwkrp_out_if                           out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [mwkrp_pkg::CfgAddrW-1:0] paddr,
  input  logic [mwkrp_pkg::CfgDataW-1:0] pwdata,
  output int                             fail_cnt,
  output int                             pending_cnt,
  output int                             result_cnt,
  output int                             ovf_cnt
);

  typedef struct packed {
    logic [mwkrp_pkg::WasteW-1:0] total_waste;
    logic                         overflow;
  } waste_t;

  logic [mwkrp_pkg::KW-1:0] resizes;
  longint unsigned          sizes [mwkrp_pkg::MaxLen];
  longint unsigned          size_sums [mwkrp_pkg::MaxLen+1];
  int                       seq_len;
  logic                     seq_dropped;
  waste_t                   waste_q [$];

  // Row-by-row segment DP; the waste of the last segment is grown leftward
  // with a running maximum, as in the block.
  function automatic logic [mwkrp_pkg::WasteW-1:0] min_waste(int n, int k);
    longint unsigned prev [mwkrp_pkg::MaxLen];
    longint unsigned next [mwkrp_pkg::MaxLen];
    longint unsigned run_max, best, seg_waste, cand;
    int segs;
    if (n <= 1 || k + 1 >= n) return '0;
    segs = k + 1;
    run_max = 0;
    for (int i = 0; i < n; i++) begin
      if (sizes[i] > run_max) run_max = sizes[i];
      prev[i] = run_max * longint'(i + 1) - size_sums[i+1];
    end
    for (int s = 2; s <= segs; s++) begin
      for (int i = 0; i < n; i++) begin
        best = prev[i];
        run_max = 0;
        for (int x = i; x > 0; x--) begin
          if (sizes[x] > run_max) run_max = sizes[x];
          seg_waste = run_max * longint'(i + 1 - x) - (size_sums[i+1] - size_sums[x]);
          cand = prev[x-1] + seg_waste;
          if (cand < best) best = cand;
        end
        next[i] = best;
      end
      prev = next;
    end
    return prev[n-1][mwkrp_pkg::WasteW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    waste_t exp_w, got_w;
    if (!rst_ni) begin
      resizes = '0;
      seq_len = 0;
      seq_dropped = 1'b0;
      size_sums[0] = 0;
      waste_q.delete();
      fail_cnt = 0;
      result_cnt = 0;
      ovf_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready
          && (paddr >> 2) == mwkrp_pkg::CfgAddrW'(mwkrp_pkg::RegMaxResizes))
        resizes = pwdata[mwkrp_pkg::KW-1:0];
      if (in_ch.valid && in_ch.ready) begin
        if (seq_len < mwkrp_pkg::MaxLen) begin
          sizes[seq_len] = in_ch.size_value;
          size_sums[seq_len+1] = size_sums[seq_len] + in_ch.size_value;
          seq_len++;
        end else begin
          seq_dropped = 1'b1;
        end
        if (in_ch.last_value) begin
          exp_w.total_waste = min_waste(seq_len, int'(resizes));
          exp_w.overflow = seq_dropped;
          waste_q.push_back(exp_w);
          seq_len = 0;
          seq_dropped = 1'b0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got_w.total_waste = out_ch.total_waste;
        got_w.overflow = out_ch.overflow;
        result_cnt++;
        if (got_w.overflow) ovf_cnt++;
        if (waste_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: unexpected result waste=%0d overflow=%0b",
                     got_w.total_waste, got_w.overflow);
        end else begin
          exp_w = waste_q.pop_front();
          if (got_w != exp_w) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: waste exp=%0d got=%0d, overflow exp=%0b got=%0b",
                       exp_w.total_waste, got_w.total_waste, exp_w.overflow,
                       got_w.overflow);
          end
        end
      end
    end
    pending_cnt = waste_q.size();
  end
endmodule

// ===== sim/min_waste_k_resize_partition_tb.sv =====
`timescale 1ns / 1ps
module min_waste_k_resize_partition_tb;

  localparam logic [mwkrp_pkg::CfgAddrW-1:0] MaxResizesAddr =
    mwkrp_pkg::CfgAddrW'(mwkrp_pkg::RegMaxResizes) << 2;
  localparam logic [mwkrp_pkg::CfgAddrW-1:0] UnusedRegAddr  = 3'd4;
  localparam int                             CycleLimit     = 4000000;
  localparam int                             SettleCycles   = 20;
  localparam int                             ResizeChoices [7] = '{0, 1, 2, 3, 5, 8, 255};

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel, penable, pwrite;
  logic [mwkrp_pkg::CfgAddrW-1:0] paddr;
  logic [mwkrp_pkg::CfgDataW-1:0] pwdata;
  logic [mwkrp_pkg::CfgDataW-1:0] prdata;
  logic                           pready;
  int                             fail_cnt, pending_cnt, result_cnt, ovf_cnt;
  int                             sent_cnt, seq_cnt, cycle_cnt;
  int                             idle_pct, stall_pct;

  mwkrp_in_if  in_ch ();
  mwkrp_out_if out_ch ();

  min_waste_k_resize_partition i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mwkrp_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .result_cnt  (result_cnt),
    .ovf_cnt     (ovf_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) out_ch.ready = ($urandom_range(99) >= stall_pct);

  task automatic cfg_write(logic [mwkrp_pkg::CfgAddrW-1:0] addr,
                           logic [mwkrp_pkg::CfgDataW-1:0] data);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Holds the item until the block takes it; called and returning at a falling edge.
  task automatic send_size(logic [mwkrp_pkg::ValueBits-1:0] size, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.size_value = size;
    in_ch.last_value = last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_cnt++;
    if (last) seq_cnt++;
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [mwkrp_pkg::ValueBits-1:0] rand_size(int style);
    case (style)
      0:       return mwkrp_pkg::ValueBits'($urandom);
      1:       return mwkrp_pkg::ValueBits'($urandom_range(15));
      2:       return mwkrp_pkg::ValueBits'(1000);
      default: return mwkrp_pkg::ValueBits'($urandom_range(1 << mwkrp_pkg::ValueBits - 1,
                                                           (1 << mwkrp_pkg::ValueBits) - 1));
    endcase
  endfunction

  // Random sequence: mostly short, now and then longer with few resizes.
  task automatic send_sequence(int k);
    int len, style;
    len = ($urandom_range(9) == 0 && k <= 3) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    style = $urandom_range(3);
    for (int i = 0; i < len; i++) send_size(rand_size(style), i == len - 1);
  endtask

  initial begin
    int k;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.size_value = '0; in_ch.last_value = 1'b0;
    out_ch.ready = 1'b1;
    idle_pct = 0; stall_pct = 0;
    sent_cnt = 0; seq_cnt = 0; cycle_cnt = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset value of the register, extremes, short sequences.
    send_size('1, 1'b1);
    send_size('0, 1'b0);
    send_size('1, 1'b1);
    send_size(20'd5, 1'b0);
    send_size(20'd1, 1'b0);
    send_size(20'd9, 1'b1);
    drain();
    cfg_write(UnusedRegAddr, 32'hFFFF_FFFF);
    cfg_write(MaxResizesAddr, 32'd1);
    send_size(20'd5, 1'b0);
    send_size(20'd1, 1'b0);
    send_size(20'd9, 1'b0);
    send_size('1, 1'b1);
    drain();
    cfg_write(MaxResizesAddr, 32'd255);
    for (int i = 0; i < 5; i++) send_size(rand_size(0), i == 4);
    drain();
    // Full store: two unmarked items and then the marked item are dropped.
    cfg_write(MaxResizesAddr, 32'd1);
    for (int i = 0; i < mwkrp_pkg::MaxLen + 3; i++) begin
      send_size(rand_size(i % 4), i == mwkrp_pkg::MaxLen + 2);
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 54 : 25) : 0;
      stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 54 : 25) : 0;
      for (int sub = 0; sub < 2; sub++) begin
        k = ResizeChoices[$urandom_range(6)];
        cfg_write(MaxResizesAddr, mwkrp_pkg::CfgDataW'(k));
        for (int j = 0; j < 4; j++) send_sequence(k);
        // Let every result come back before the sender resumes.
        drain();
      end
    end
    drain();

    $display("sent %0d items in %0d sequences, %0d results checked (%0d with overflow)",
             sent_cnt, seq_cnt, result_cnt, ovf_cnt);
    $display("covered resize counts from 0 to 255 under sender gaps and receiver stalls");
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/mwkrp_pkg.sv
rtl/mwkrp_in_if.sv
rtl/mwkrp_out_if.sv
rtl/mwkrp_ram.sv
rtl/min_waste_k_resize_partition.sv
sim/mwkrp_checker.sv
sim/min_waste_k_resize_partition_tb.sv
